[hdl/bmd_pkg.sv]
// ----------------------------------------------------------------------------
// bmd_pkg: shared constants and types for the background motion detector
// Widths of the stream fields, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int MAX_PIXELS_DEF = 65536;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int PIX_W     = 8;
    localparam int IDX_W     = 16;
    localparam int THR_W     = 8;
    localparam int WGT_CFG_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [THR_W-1:0]     MOTION_THR_RST   = 8'd8;
    localparam logic [THR_W-1:0]     PRESENCE_THR_RST = 8'd8;
    localparam logic [WGT_CFG_W-1:0] MOTION_WGT_RST   = 17'd32768;
    localparam logic [WGT_CFG_W-1:0] PRESENCE_WGT_RST = 17'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTION_THR   = 2'd0,
        REG_PRESENCE_THR = 2'd1,
        REG_MOTION_WGT   = 2'd2,
        REG_PRESENCE_WGT = 2'd3
    } cfg_reg_t;

endpackage

[hdl/bmd_ram.sv]
// ----------------------------------------------------------------------------
// bmd_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/background_motion_detector.sv]
// ----------------------------------------------------------------------------
// background_motion_detector: running-average background subtraction
// Result word registered after the read, difference, multiply and write-back stages.
// Throughput: one pixel per cycle while m_tready is high. A pixel whose index
// matches one of the (up to three) pixels not yet written back waits until
// that write is done.
// Reset (aresetn, synchronous): clears pipeline valids, restores config
// defaults. Store contents are not cleared: a pixel must be reinit first.
// ----------------------------------------------------------------------------
module background_motion_detector
    import bmd_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WGT_CFG_W-1:0]  cfg_wdata,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value, [23:8] pixel_index
    input  logic                  s_tuser,   // [0] reinit
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [15:0] out_index, [16] motion_flag,
                                             // [17] presence_flag, [23:18] zero
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = PIX_W + FRAC_BITS;        // store word, Q8.FRAC_BITS
    localparam int WW = FRAC_BITS + 1;            // clamped weight
    localparam int DW = SW + 1;                   // signed difference
    localparam int PW = DW + WW + 1;              // signed product / accumulator
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    function automatic logic [WW-1:0] clamp_w(input logic [WGT_CFG_W-1:0] w);
        logic [31:0] w32;
        logic [31:0] one32;
        w32   = 32'(w);
        one32 = 32'(1) << FRAC_BITS;
        if (w32 > one32) begin
            w32 = one32;
        end
        return w32[WW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [THR_W-1:0] mthr_reg, pthr_reg;
    logic [WW-1:0]    mwgt_reg, pwgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mthr_reg <= MOTION_THR_RST;
            pthr_reg <= PRESENCE_THR_RST;
            mwgt_reg <= clamp_w(MOTION_WGT_RST);
            pwgt_reg <= clamp_w(PRESENCE_WGT_RST);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_MOTION_THR:   mthr_reg <= cfg_wdata[THR_W-1:0];
                REG_PRESENCE_THR: pthr_reg <= cfg_wdata[THR_W-1:0];
                REG_MOTION_WGT:   mwgt_reg <= clamp_w(cfg_wdata);
                REG_PRESENCE_WGT: pwgt_reg <= clamp_w(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic [PIX_W-1:0] in_pix;
    logic [IDX_W-1:0] in_idx;
    logic [31:0]      in_idx32;
    logic [AW-1:0]    in_addr;
    logic             in_range;

    assign in_pix   = s_tdata[PIX_W-1:0];
    assign in_idx   = s_tdata[PIX_W +: IDX_W];
    assign in_idx32 = 32'(in_idx);
    assign in_addr  = in_idx32[AW-1:0];
    assign in_range = in_idx32 < 32'(MAX_PIXELS);

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;
    logic hazard, accept;

    logic [IDX_W-1:0] p1_idx_reg, p2_idx_reg, p3_idx_reg, p4_idx_reg;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    // same entry still waiting for its write-back: hold the new word
    assign hazard = (v1_reg && (p1_idx_reg == in_idx)) ||
                    (v2_reg && (p2_idx_reg == in_idx)) ||
                    (v3_reg && (p3_idx_reg == in_idx));

    assign s_tready = en1 && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        v1_next = en1 ? accept : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
        v4_next = en4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ---------------- stores ----------------
    logic          wr_en;
    logic [AW-1:0] p1_addr_reg, p2_addr_reg, p3_addr_reg;
    logic [SW-1:0] rd_recent, rd_backgr;
    logic [SW-1:0] wr_recent, wr_backgr;

    bmd_ram #(.WIDTH(SW), .DEPTH(MAX_PIXELS)) u_recent_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (p3_addr_reg),
        .wdata (wr_recent),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_recent)
    );

    bmd_ram #(.WIDTH(SW), .DEPTH(MAX_PIXELS)) u_backgr_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (p3_addr_reg),
        .wdata (wr_backgr),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_backgr)
    );

    // ---------------- stage 1: read issued ----------------
    logic [PIX_W-1:0] p1_pix_reg;
    logic             p1_reinit_reg, p1_range_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_pix_reg    <= in_pix;
            p1_idx_reg    <= in_idx;
            p1_addr_reg   <= in_addr;
            p1_reinit_reg <= s_tuser;
            p1_range_reg  <= in_range;
        end
    end

    // ---------------- stage 2: differences and flags ----------------
    logic [SW-1:0]        pix_fx;
    logic [SW-1:0]        avg_r_next, avg_b_next;
    logic signed [DW-1:0] d_r_next, d_b_next;
    logic [DW-1:0]        ad_r, ad_b;
    logic                 mflag_next, pflag_next;

    assign pix_fx = {p1_pix_reg, {FRAC_BITS{1'b0}}};

    always_comb begin
        // reinit loads the sample, so both differences come out zero
        avg_r_next = p1_reinit_reg ? pix_fx : rd_recent;
        avg_b_next = p1_reinit_reg ? pix_fx : rd_backgr;
        d_r_next   = $signed({1'b0, pix_fx}) - $signed({1'b0, avg_r_next});
        d_b_next   = $signed({1'b0, pix_fx}) - $signed({1'b0, avg_b_next});
        ad_r       = d_r_next[DW-1] ? DW'(-d_r_next) : DW'(d_r_next);
        ad_b       = d_b_next[DW-1] ? DW'(-d_b_next) : DW'(d_b_next);
        mflag_next = p1_range_reg && (ad_r[FRAC_BITS +: PIX_W] > mthr_reg);
        pflag_next = p1_range_reg && (ad_b[FRAC_BITS +: PIX_W] > pthr_reg);
    end

    logic [SW-1:0]        p2_avg_r_reg, p2_avg_b_reg;
    logic signed [DW-1:0] p2_d_r_reg, p2_d_b_reg;
    logic                 p2_mflag_reg, p2_pflag_reg, p2_range_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            p2_avg_r_reg <= avg_r_next;
            p2_avg_b_reg <= avg_b_next;
            p2_d_r_reg   <= d_r_next;
            p2_d_b_reg   <= d_b_next;
            p2_mflag_reg <= mflag_next;
            p2_pflag_reg <= pflag_next;
            p2_range_reg <= p1_range_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_addr_reg  <= p1_addr_reg;
        end
    end

    // ---------------- stage 3: weight multiply ----------------
    // avg*(1-w) + pix*w == avg*1 + (pix - avg)*w
    logic signed [PW-1:0] prod_r_next, prod_b_next;

    assign prod_r_next = p2_d_r_reg * $signed({1'b0, mwgt_reg});
    assign prod_b_next = p2_d_b_reg * $signed({1'b0, pwgt_reg});

    logic [SW-1:0]        p3_avg_r_reg, p3_avg_b_reg;
    logic signed [PW-1:0] p3_prod_r_reg, p3_prod_b_reg;
    logic                 p3_mflag_reg, p3_pflag_reg, p3_range_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            p3_avg_r_reg  <= p2_avg_r_reg;
            p3_avg_b_reg  <= p2_avg_b_reg;
            p3_prod_r_reg <= prod_r_next;
            p3_prod_b_reg <= prod_b_next;
            p3_mflag_reg  <= p2_mflag_reg;
            p3_pflag_reg  <= p2_pflag_reg;
            p3_range_reg  <= p2_range_reg;
            p3_idx_reg    <= p2_idx_reg;
            p3_addr_reg   <= p2_addr_reg;
        end
    end

    // ---------------- stage 4: round, write back, result ----------------
    logic signed [PW-1:0] acc_r, acc_b;

    assign acc_r = $signed({3'b000, p3_avg_r_reg, {FRAC_BITS{1'b0}}}) + p3_prod_r_reg
                 + $signed(HALF);
    assign acc_b = $signed({3'b000, p3_avg_b_reg, {FRAC_BITS{1'b0}}}) + p3_prod_b_reg
                 + $signed(HALF);

    assign wr_recent = acc_r[FRAC_BITS +: SW];
    assign wr_backgr = acc_b[FRAC_BITS +: SW];
    assign wr_en     = v3_reg && en4 && p3_range_reg;

    logic p4_mflag_reg, p4_pflag_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            p4_idx_reg   <= p3_idx_reg;
            p4_mflag_reg <= p3_mflag_reg;
            p4_pflag_reg <= p3_pflag_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {(M_TDATA_W - IDX_W - 2)'(0), p4_pflag_reg, p4_mflag_reg, p4_idx_reg};

endmodule
